[hdl/heat_stencil_step_defines.svh]
// Assertion macros for the heat stencil block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef HEAT_STENCIL_STEP_DEFINES_SVH
`define HEAT_STENCIL_STEP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Condition must hold at every clock edge out of reset.
`define HSS_ASSERT(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("heat_stencil_step: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define HSS_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("heat_stencil_step: implication violated");

// Consequent must hold in the cycle after the antecedent.
`define HSS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("heat_stencil_step: next-cycle implication violated");

`else

`define HSS_ASSERT(label, cond)
`define HSS_ASSERT_IMPL(label, pre, post)
`define HSS_ASSERT_NEXT(label, pre, post)

`endif

`endif

[hdl/hss_pkg.sv]
// Shared constants, codes and types of the heat stencil block.
// No dependencies; every file but the assertion macro header imports this package.
`timescale 1ns / 1ps

package hss_pkg;

  localparam int unsigned DataBits    = 16;
  localparam int unsigned MaxWidth    = 1024;
  localparam int unsigned HeightLimit = 1024;
  localparam int unsigned MinDim      = 3;
  localparam int unsigned DimBits     = 11;
  localparam int unsigned PosBits     = $clog2(MaxWidth);
  localparam int unsigned SDimBits    = DimBits + 2;
  localparam int unsigned CoeffBits   = 16;
  localparam int unsigned CoeffFrac   = 16;
  localparam int unsigned LapBits     = DataBits + 3;
  localparam int unsigned ProdBits    = LapBits + CoeffBits + 1;
  localparam int unsigned DeltaBits   = ProdBits - CoeffFrac;
  localparam int unsigned SumBits     = DeltaBits + 1;

  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 16;

  localparam int unsigned QDepth      = 4;
  localparam int unsigned QPtrBits    = $clog2(QDepth);
  localparam int unsigned QCntBits    = $clog2(QDepth + 1);
  localparam int unsigned QUseBits    = QCntBits + 1;

  localparam logic [DimBits-1:0]   WidthReset  = 11'd64;
  localparam logic [DimBits-1:0]   HeightReset = 11'd64;
  localparam logic [CoeffBits-1:0] CoeffReset  = 16'd16384;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_STEP_COEFF  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_DRAIN  = 1'b1
  } req_e;

  typedef logic signed [DataBits-1:0] cell_t;

  // One classified word on its way from the front end to the compute back end.
  typedef struct packed {
    logic  is_sample;
    logic  emit;
    logic  full;
    logic  on_edge;
    logic  is_last;
    cell_t temp;
    cell_t mid;
    cell_t upper;
  } q_item_t;

endpackage

[hdl/hss_in_if.sv]
// Input word channel of the heat stencil block.
// Depends on hss_pkg for the cell width.
`timescale 1ns / 1ps

interface hss_in_if;
  import hss_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic signed [DataBits-1:0] temp_in;

  modport source (output valid, req_type, temp_in, input ready);
  modport sink   (input valid, req_type, temp_in, output ready);
endinterface

[hdl/hss_out_if.sv]
// Result word channel of the heat stencil block.
// Depends on hss_pkg for the cell width.
`timescale 1ns / 1ps

interface hss_out_if;
  import hss_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [DataBits-1:0] temp_out;
  logic                       on_frame_edge;
  logic                       last_of_frame;

  modport source (output valid, temp_out, on_frame_edge, last_of_frame, input ready);
  modport sink   (input valid, temp_out, on_frame_edge, last_of_frame, output ready);
endinterface

[hdl/hss_cfg_if.sv]
// Configuration write channel of the heat stencil block.
// Depends on hss_pkg for index and data widths.
`timescale 1ns / 1ps

interface hss_cfg_if;
  import hss_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CfgIdxBits-1:0]  index;
  logic [CfgDataBits-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/hss_queue.sv]
// Short FIFO of classified words between the front end and the back end.
// Depends on hss_pkg for q_item_t and the queue depth.
`timescale 1ns / 1ps

module hss_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  hss_pkg::q_item_t              item_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output hss_pkg::q_item_t              item_o,
  output logic [hss_pkg::QCntBits-1:0]  count_o
);
  import hss_pkg::*;

  q_item_t               slot_q [QDepth];
  logic [QPtrBits-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntBits-1:0]   count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCntBits'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrBits'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrBits'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign item_o  = slot_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

[hdl/hss_front.sv]
// Front end: accepts words, tracks grid position and pending count,
// classifies the oldest pending cell and owns the two line stores. Uses hss_pkg.
`timescale 1ns / 1ps

module hss_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hss_in_if.sink                        in_i,
  input  logic [hss_pkg::DimBits-1:0]   grid_width_i,
  input  logic [hss_pkg::DimBits-1:0]   grid_height_i,
  input  logic [hss_pkg::QCntBits-1:0]  q_count_i,
  output logic                          push_o,
  output hss_pkg::q_item_t              item_o
);
  import hss_pkg::*;

  function automatic logic [DimBits-1:0] clamp_dim(input logic [DimBits-1:0] v,
                                                   input logic [DimBits-1:0] limit);
    logic [DimBits-1:0] r;
    r = v;
    if (v < DimBits'(MinDim)) begin
      r = DimBits'(MinDim);
    end else if (v > limit) begin
      r = limit;
    end
    return r;
  endfunction

  // Line stores: no reset, contents are defined once written.
  cell_t mid_mem [MaxWidth];
  cell_t upp_mem [MaxWidth];

  logic [PosBits-1:0]  row_q, row_d, col_q, col_d;
  logic [DimBits-1:0]  pend_q, pend_d;

  logic [DimBits-1:0]  wd, ht, wd1, row_t, col_inc, row_inc;
  logic [PosBits-1:0]  col_f, row_f, row_m1, row_m2, old_col, old_row, mid_addr;
  logic [DimBits-1:0]  pend_f;
  logic signed [SDimBits-1:0] dcol0, dcol1, dcol2;
  logic                full, on_edge, is_last, is_drain, take, push_now;
  logic [QUseBits-1:0] q_used;

  // Stage 1: classification plus registered store reads.
  logic                s1_valid_q;
  logic                s1_sample_q, s1_emit_q, s1_full_q, s1_edge_q, s1_last_q;
  logic [PosBits-1:0]  s1_col_q;
  cell_t               s1_temp_q, mid_rd_q, upp_rd_q, upp_fwd_q;
  logic                upp_hit_q;

  // One word may be in stage 1 on top of what the queue holds.
  assign q_used     = QUseBits'(q_count_i) + QUseBits'(s1_valid_q);
  assign in_i.ready = (q_used < QUseBits'(QDepth));

  always_comb begin
    wd  = clamp_dim(grid_width_i, DimBits'(MaxWidth));
    ht  = clamp_dim(grid_height_i, DimBits'(HeightLimit));
    wd1 = wd + DimBits'(1);

    // Fold a position left beyond the grid by a geometry change.
    col_f = col_q;
    row_t = DimBits'(row_q);
    if (DimBits'(col_q) >= wd) begin
      col_f = '0;
      row_t = DimBits'(row_q) + DimBits'(1);
    end
    row_f  = (row_t >= ht) ? '0 : row_t[PosBits-1:0];
    pend_f = (pend_q > wd1) ? wd1 : pend_q;
    full   = (pend_f == wd1);

    // The oldest pending cell lies at most two rows behind the input position.
    row_m1 = (row_f == '0) ? PosBits'(ht - DimBits'(1)) : row_f - PosBits'(1);
    row_m2 = (row_m1 == '0) ? PosBits'(ht - DimBits'(1)) : row_m1 - PosBits'(1);
    dcol0  = $signed(SDimBits'(col_f)) - $signed(SDimBits'(pend_f));
    dcol1  = dcol0 + $signed(SDimBits'(wd));
    dcol2  = dcol1 + $signed(SDimBits'(wd));
    if (!dcol0[SDimBits-1]) begin
      old_col = dcol0[PosBits-1:0];
      old_row = row_f;
    end else if (!dcol1[SDimBits-1]) begin
      old_col = dcol1[PosBits-1:0];
      old_row = row_m1;
    end else begin
      old_col = dcol2[PosBits-1:0];
      old_row = row_m2;
    end
    on_edge = (old_row == '0) || (DimBits'(old_row) == ht - DimBits'(1)) ||
              (old_col == '0) || (DimBits'(old_col) == wd - DimBits'(1));
    is_last = (DimBits'(old_row) == ht - DimBits'(1)) &&
              (DimBits'(old_col) == wd - DimBits'(1));

    is_drain = (in_i.req_type == REQ_DRAIN);
    take     = in_i.valid && in_i.ready;
    push_now = take && (!is_drain || (pend_f != '0));

    // A partial drain passes the oldest cell straight from the middle store.
    mid_addr = (is_drain && !full) ? old_col : col_f;

    col_inc = DimBits'(col_f) + DimBits'(1);
    row_inc = DimBits'(row_f) + DimBits'(1);

    row_d  = row_q;
    col_d  = col_q;
    pend_d = pend_q;
    if (take) begin
      row_d  = row_f;
      col_d  = col_f;
      pend_d = pend_f;
      if (!is_drain) begin
        if (!full) begin
          pend_d = pend_f + DimBits'(1);
        end
        if (col_inc >= wd) begin
          col_d = '0;
          row_d = (row_inc >= ht) ? '0 : row_inc[PosBits-1:0];
        end else begin
          col_d = col_inc[PosBits-1:0];
        end
      end else if (pend_f != '0) begin
        pend_d = pend_f - DimBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      pend_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      row_q      <= row_d;
      col_q      <= col_d;
      pend_q     <= pend_d;
      s1_valid_q <= push_now;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      mid_rd_q    <= mid_mem[mid_addr];
      upp_rd_q    <= upp_mem[col_f];
      // The upper store write of the word in stage 1 lands this cycle.
      upp_hit_q   <= s1_valid_q && s1_sample_q && (s1_col_q == col_f);
      upp_fwd_q   <= mid_rd_q;
      s1_sample_q <= !is_drain;
      s1_emit_q   <= is_drain || full;
      s1_full_q   <= full;
      s1_edge_q   <= on_edge;
      s1_last_q   <= is_last;
      s1_col_q    <= col_f;
      s1_temp_q   <= in_i.temp_in;
    end
    if (take && !is_drain) begin
      mid_mem[col_f] <= in_i.temp_in;
    end
    // The old middle value of the column moves up one row.
    if (s1_valid_q && s1_sample_q) begin
      upp_mem[s1_col_q] <= mid_rd_q;
    end
  end

  always_comb begin
    item_o.is_sample = s1_sample_q;
    item_o.emit      = s1_emit_q;
    item_o.full      = s1_full_q;
    item_o.on_edge   = s1_edge_q;
    item_o.is_last   = s1_last_q;
    item_o.temp      = s1_temp_q;
    item_o.mid       = mid_rd_q;
    item_o.upper     = upp_hit_q ? upp_fwd_q : upp_rd_q;
  end

  assign push_o = s1_valid_q;

endmodule

[hdl/hss_back.sv]
// Back end: holds the stencil window, computes the Euler update and drives
// the registered result channel. Uses hss_pkg and hss_out_if.
`timescale 1ns / 1ps

module hss_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  hss_pkg::q_item_t              q_item_i,
  output logic                          q_pop_o,
  input  logic [hss_pkg::CoeffBits-1:0] step_coeff_i,
  hss_out_if.source                     out_o
);
  import hss_pkg::*;

  // Window: three rows of the newest column plus the middle of the one before.
  cell_t win_top_q, win_mid_q, win_bot_q, prev_mid_q;

  logic adv, pop;
  logic signed [LapBits-1:0]   lap;
  logic signed [CoeffBits:0]   coeff_s;
  logic signed [DeltaBits-1:0] delta;
  logic signed [SumBits-1:0]   sum;
  cell_t                       sat;

  logic                        b1_valid_q, b1_bypass_q, b1_edge_q, b1_last_q;
  logic signed [LapBits-1:0]   b1_lap_q;
  cell_t                       b1_center_q, b1_raw_q;

  logic                        b2_valid_q, b2_bypass_q, b2_edge_q, b2_last_q;
  logic signed [ProdBits-1:0]  b2_prod_q;
  cell_t                       b2_center_q, b2_raw_q;

  logic                        out_valid_q, out_edge_q, out_last_q;
  cell_t                       out_temp_q;

  assign adv     = !out_valid_q || out_o.ready;
  assign pop     = adv && q_valid_i;
  assign q_pop_o = pop;

  always_comb begin
    lap = LapBits'(win_top_q) + LapBits'(win_bot_q) + LapBits'(prev_mid_q) +
          LapBits'(q_item_i.mid) - (LapBits'(win_mid_q) <<< 2);
    coeff_s = $signed({1'b0, step_coeff_i});
    // Arithmetic right shift floors the product with the Q0.16 coefficient to a whole LSB.
    delta = b2_prod_q[ProdBits-1:CoeffFrac];
    sum   = SumBits'(b2_center_q) + SumBits'(delta);
    if (sum[SumBits-1] && !(&sum[SumBits-2:DataBits-1])) begin
      sat = {1'b1, {(DataBits-1){1'b0}}};
    end else if (!sum[SumBits-1] && (|sum[SumBits-2:DataBits-1])) begin
      sat = {1'b0, {(DataBits-1){1'b1}}};
    end else begin
      sat = sum[DataBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_top_q   <= '0;
      win_mid_q   <= '0;
      win_bot_q   <= '0;
      prev_mid_q  <= '0;
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop && q_item_i.is_sample) begin
        prev_mid_q <= win_mid_q;
        win_top_q  <= q_item_i.upper;
        win_mid_q  <= q_item_i.mid;
        win_bot_q  <= q_item_i.temp;
      end
      if (adv) begin
        b1_valid_q  <= pop && q_item_i.emit;
        b2_valid_q  <= b1_valid_q;
        out_valid_q <= b2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_lap_q    <= lap;
      b1_center_q <= win_mid_q;
      b1_raw_q    <= q_item_i.full ? win_mid_q : q_item_i.mid;
      b1_bypass_q <= !q_item_i.full || q_item_i.on_edge;
      b1_edge_q   <= q_item_i.on_edge;
      b1_last_q   <= q_item_i.is_last;

      b2_prod_q   <= b1_lap_q * coeff_s;
      b2_center_q <= b1_center_q;
      b2_raw_q    <= b1_raw_q;
      b2_bypass_q <= b1_bypass_q;
      b2_edge_q   <= b1_edge_q;
      b2_last_q   <= b1_last_q;

      out_temp_q  <= b2_bypass_q ? b2_raw_q : sat;
      out_edge_q  <= b2_edge_q;
      out_last_q  <= b2_last_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.temp_out      = out_temp_q;
  assign out_o.on_frame_edge = out_edge_q;
  assign out_o.last_of_frame = out_last_q;

endmodule

[hdl/heat_stencil_step.sv]
// Heat equation stencil step, top level: configuration registers, front end, queue, back end.
// Throughput is one word per clock while the queue has room; per clock each line store
// takes one read and one write. Words pass stage 1, the queue, b1, b2 and the output register.
// Reset clears position, pending count, window and pipeline and loads 64, 64 and 16384;
// the line stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`include "heat_stencil_step_defines.svh"

module heat_stencil_step (
  input  logic      clk_i,
  input  logic      rst_ni,
  hss_cfg_if.sink   cfg_i,
  hss_in_if.sink    in_i,
  hss_out_if.source out_o
);
  import hss_pkg::*;

  logic [DimBits-1:0]   grid_width_q, grid_height_q;
  logic [CoeffBits-1:0] step_coeff_q;

  logic                 q_push, q_pop, q_valid;
  q_item_t              push_item, pop_item;
  logic [QCntBits-1:0]  q_count;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= WidthReset;
      grid_height_q <= HeightReset;
      step_coeff_q  <= CoeffReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_GRID_WIDTH: begin
          grid_width_q <= cfg_i.data[DimBits-1:0];
        end
        CFG_GRID_HEIGHT: begin
          grid_height_q <= cfg_i.data[DimBits-1:0];
        end
        CFG_STEP_COEFF: begin
          step_coeff_q <= cfg_i.data[CoeffBits-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  hss_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .grid_width_i  (grid_width_q),
    .grid_height_i (grid_height_q),
    .q_count_i     (q_count),
    .push_o        (q_push),
    .item_o        (push_item)
  );

  hss_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (pop_item),
    .count_o (q_count)
  );

  hss_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (pop_item),
    .q_pop_o      (q_pop),
    .step_coeff_i (step_coeff_q),
    .out_o        (out_o)
  );

  // The front end's credit check must keep the queue from overflowing.
  `HSS_ASSERT(a_queue_bound, q_count <= QCntBits'(QDepth))
  `HSS_ASSERT_IMPL(a_push_has_room, q_push, q_count < QCntBits'(QDepth))
  // Every accepted sample word moves the window, so it must reach the queue.
  `HSS_ASSERT_NEXT(a_sample_reaches_queue,
                   in_i.valid && in_i.ready && (in_i.req_type == REQ_SAMPLE), q_push)

endmodule
